// ===== rtl/core/rtccal_pkg.sv =====
// Shared types and constants for the real-time clock and calendar block.
package rtccal_pkg;

	localparam int unsigned IN_DATA_W  = 48;
	localparam int unsigned OUT_DATA_W = 40;

	localparam logic [6:0] SEC_LIMIT   = 7'd60;
	localparam logic [6:0] MIN_LIMIT   = 7'd60;
	localparam logic [5:0] HOUR_LIMIT  = 6'd24;
	localparam logic [5:0] DAY_SHORT   = 6'd29;
	localparam logic [5:0] DAY_30      = 6'd31;
	localparam logic [5:0] DAY_31      = 6'd32;
	localparam logic [4:0] MONTH_LIMIT = 5'd13;
	localparam logic [7:0] YEAR_BAD    = 8'hFF;

	localparam logic [3:0] MON_FEB = 4'd2;
	localparam logic [3:0] MON_APR = 4'd4;
	localparam logic [3:0] MON_JUN = 4'd6;
	localparam logic [3:0] MON_SEP = 4'd9;
	localparam logic [3:0] MON_NOV = 4'd11;

	typedef enum logic {
		REQ_TICK = 1'b0,
		REQ_SET  = 1'b1
	} req_t;

	typedef struct packed {
		logic [7:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} rtc_time_t;

	typedef struct packed {
		logic year;
		logic month;
		logic day;
		logic hour;
		logic minute;
	} rtc_event_t;

	typedef struct packed {
		logic [7:0] set_second;
		logic [7:0] set_minute;
		logic [7:0] set_hour;
		logic [4:0] set_day;
		logic [3:0] set_month;
		logic [7:0] set_year;
	} rtc_req_t;

	localparam rtc_time_t TIME_RESET = '{
		year: 8'd0, month: 4'd1, day: 5'd1, hour: 5'd0, minute: 6'd0, second: 6'd0
	};

endpackage

// ===== rtl/core/rtccal_next.sv =====
// Next-state logic: tick carry chain and set-time load.
module rtccal_next (
	input  rtccal_pkg::req_t       req_type,
	input  rtccal_pkg::rtc_req_t   req,
	input  rtccal_pkg::rtc_time_t  cur,
	output rtccal_pkg::rtc_time_t  nxt,
	output rtccal_pkg::rtc_event_t ev
);
	import rtccal_pkg::*;

	logic [6:0] sec_inc;
	logic [6:0] min_inc;
	logic [5:0] hour_inc;
	logic [5:0] day_inc;
	logic [4:0] month_inc;
	logic       sec_carry;
	logic       min_carry;
	logic       hour_carry;
	logic       day_carry;
	logic       month_carry;
	logic       day_stays;
	logic       leap;
	rtc_time_t  tick_time;
	rtc_event_t tick_ev;
	rtc_time_t  set_time;

	assign sec_inc   = {1'b0, cur.second} + 7'd1;
	assign min_inc   = {1'b0, cur.minute} + 7'd1;
	assign hour_inc  = {1'b0, cur.hour} + 6'd1;
	assign day_inc   = {1'b0, cur.day} + 6'd1;
	assign month_inc = {1'b0, cur.month} + 5'd1;
	assign leap      = (cur.year[1:0] == 2'd0);

	always_comb begin
		if (day_inc < DAY_SHORT) begin
			day_stays = 1'b1;
		end else if (cur.month == MON_FEB) begin
			day_stays = (day_inc == DAY_SHORT) && leap;
		end else if (cur.month == MON_APR || cur.month == MON_JUN ||
				cur.month == MON_SEP || cur.month == MON_NOV) begin
			day_stays = (day_inc < DAY_30);
		end else begin
			day_stays = (day_inc < DAY_31);
		end
	end

	assign sec_carry   = (sec_inc >= SEC_LIMIT);
	assign min_carry   = sec_carry && (min_inc >= MIN_LIMIT);
	assign hour_carry  = min_carry && (hour_inc >= HOUR_LIMIT);
	assign day_carry   = hour_carry && !day_stays;
	assign month_carry = day_carry && (month_inc >= MONTH_LIMIT);

	always_comb begin
		tick_time = cur;
		tick_time.second = sec_carry ? 6'd0 : sec_inc[5:0];
		if (sec_carry) begin
			tick_time.minute = min_carry ? 6'd0 : min_inc[5:0];
		end
		if (min_carry) begin
			tick_time.hour = hour_carry ? 5'd0 : hour_inc[4:0];
		end
		if (hour_carry) begin
			tick_time.day = day_carry ? 5'd1 : day_inc[4:0];
		end
		if (day_carry) begin
			tick_time.month = month_carry ? 4'd1 : month_inc[3:0];
		end
		if (month_carry) begin
			tick_time.year = cur.year + 8'd1;
		end
		tick_ev = '{year: month_carry, month: day_carry, day: hour_carry,
			hour: min_carry, minute: sec_carry};
	end

	always_comb begin
		set_time.year   = (req.set_year == YEAR_BAD) ? 8'd0 : req.set_year;
		set_time.month  = req.set_month;
		set_time.day    = req.set_day;
		set_time.hour   = (req.set_hour > 8'd23) ? 5'd0 : req.set_hour[4:0];
		set_time.minute = (req.set_minute > 8'd59) ? 6'd0 : req.set_minute[5:0];
		set_time.second = (req.set_second > 8'd59) ? 6'd0 : req.set_second[5:0];
	end

	always_comb begin
		case (req_type)
			REQ_SET: begin
				nxt = set_time;
				ev  = '0;
			end
			default: begin
				nxt = tick_time;
				ev  = tick_ev;
			end
		endcase
	end

endmodule

// ===== rtl/core/rtc_calendar_tick.sv =====
// Top level: input register, calendar counters and result register.
// An accepted item waits in the input register; its result is registered once the result register is free.
// Throughput: one tick or set item per cycle while m_tready holds; the counters update as each item moves on.
// Ready stalls only when both the input and result registers hold items and m_tready is low.
// Reset: counters go to 00:00:00, day 1, month 1, year 0; both stages empty.
module rtc_calendar_tick (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// set_year, set_month, set_day, set_hour, set_minute, set_second, zero fill
	input  logic [rtccal_pkg::IN_DATA_W-1:0]  s_tdata,
	// req_type
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// out_second, out_minute, out_hour, out_day, out_month, out_year,
	// minute_event, hour_event, day_event, month_event, year_event, zero fill
	output logic [rtccal_pkg::OUT_DATA_W-1:0] m_tdata
);
	import rtccal_pkg::*;

	logic       valid_s1;
	req_t       type_s1;
	rtc_req_t   req_s1;
	logic       valid_s2;
	rtc_time_t  time_s2;
	rtc_event_t ev_s2;
	rtc_time_t  time_q;
	rtc_time_t  time_nxt;
	rtc_event_t ev_nxt;
	logic       adv_s2;
	logic       adv_s1;

	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign s_tready = !valid_s1 || adv_s2;

	rtccal_next u_next (
		.req_type (type_s1),
		.req      (req_s1),
		.cur      (time_q),
		.nxt      (time_nxt),
		.ev       (ev_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			time_q   <= TIME_RESET;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				time_q <= time_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			type_s1 <= req_t'(s_tuser);
			req_s1  <= '{
				set_second: s_tdata[40:33],
				set_minute: s_tdata[32:25],
				set_hour:   s_tdata[24:17],
				set_day:    s_tdata[16:12],
				set_month:  s_tdata[11:8],
				set_year:   s_tdata[7:0]
			};
		end
		if (adv_s1) begin
			time_s2 <= time_nxt;
			ev_s2   <= ev_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0,
		ev_s2.year, ev_s2.month, ev_s2.day, ev_s2.hour, ev_s2.minute,
		time_s2.year, time_s2.month, time_s2.day,
		time_s2.hour, time_s2.minute, time_s2.second};

endmodule

// ===== tb/sv/rtc_calendar_tick_tb.sv =====
// Testbench for rtc_calendar_tick: directed and random items checked against expected results and a predictor.
module rtc_calendar_tick_tb;
	import rtccal_pkg::*;

	localparam int ITEM_COUNT   = 1600;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_WAIT     = 14;

	typedef struct packed {
		logic       pad;
		rtc_event_t ev;
		rtc_time_t  tm;
	} cal_result_t;

	typedef struct {
		req_t        kind;
		rtc_req_t    req;
		bit          typed;
		cal_result_t res;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	logic [5:0] cal_sec;
	logic [5:0] cal_min;
	logic [4:0] cal_hour;
	logic [4:0] cal_day;
	logic [3:0] cal_mon;
	logic [7:0] cal_year;

	cal_result_t calendar_due[$];
	dir_row_t    dir_tab[$];

	int err_count   = 0;
	int tick_count  = 0;
	int set_count   = 0;
	int cycle_count = 0;
	int carry_min   = 0;
	int carry_hour  = 0;
	int carry_day   = 0;
	int carry_mon   = 0;
	int carry_year  = 0;
	bit burst       = 1'b0;

	rtc_calendar_tick dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic bit day_fits(logic [5:0] d);
		if (d < DAY_SHORT)
			return 1'b1;
		if (cal_mon == MON_FEB)
			return (d == DAY_SHORT) && (cal_year[1:0] == 2'b00);
		if (cal_mon == MON_APR || cal_mon == MON_JUN || cal_mon == MON_SEP ||
				cal_mon == MON_NOV)
			return d < DAY_30;
		return d < DAY_31;
	endfunction

	function automatic cal_result_t advance_calendar(req_t kind, rtc_req_t rq);
		cal_result_t r;
		logic [6:0]  nxt;
		r = '0;
		if (kind == REQ_SET) begin
			cal_year = (rq.set_year == YEAR_BAD) ? 8'd0 : rq.set_year;
			cal_mon  = rq.set_month;
			cal_day  = rq.set_day;
			cal_hour = (rq.set_hour > 8'd23) ? 5'd0 : rq.set_hour[4:0];
			cal_min  = (rq.set_minute > 8'd59) ? 6'd0 : rq.set_minute[5:0];
			cal_sec  = (rq.set_second > 8'd59) ? 6'd0 : rq.set_second[5:0];
		end else begin
			nxt = {1'b0, cal_sec} + 7'd1;
			if (nxt < SEC_LIMIT) begin
				cal_sec = nxt[5:0];
			end else begin
				cal_sec = 6'd0;
				r.ev.minute = 1'b1;
				nxt = {1'b0, cal_min} + 7'd1;
				if (nxt < MIN_LIMIT) begin
					cal_min = nxt[5:0];
				end else begin
					cal_min = 6'd0;
					r.ev.hour = 1'b1;
					nxt = {2'b0, cal_hour} + 7'd1;
					if (nxt < HOUR_LIMIT) begin
						cal_hour = nxt[4:0];
					end else begin
						cal_hour = 5'd0;
						r.ev.day = 1'b1;
						nxt = {2'b0, cal_day} + 7'd1;
						if (day_fits(nxt[5:0])) begin
							cal_day = nxt[4:0];
						end else begin
							cal_day = 5'd1;
							r.ev.month = 1'b1;
							nxt = {3'b0, cal_mon} + 7'd1;
							if (nxt < MONTH_LIMIT) begin
								cal_mon = nxt[3:0];
							end else begin
								cal_mon = 4'd1;
								cal_year = cal_year + 8'd1;
								r.ev.year = 1'b1;
							end
						end
					end
				end
			end
		end
		r.tm.second = cal_sec;
		r.tm.minute = cal_min;
		r.tm.hour   = cal_hour;
		r.tm.day    = cal_day;
		r.tm.month  = cal_mon;
		r.tm.year   = cal_year;
		return r;
	endfunction

	function automatic cal_result_t mk_res(int sec, int mn, int hr, int dy, int mo, int yr,
			logic [4:0] ev);
		cal_result_t r;
		r = '0;
		r.tm.second = 6'(sec);
		r.tm.minute = 6'(mn);
		r.tm.hour   = 5'(hr);
		r.tm.day    = 5'(dy);
		r.tm.month  = 4'(mo);
		r.tm.year   = 8'(yr);
		r.ev        = rtc_event_t'(ev);
		return r;
	endfunction

	task automatic add_row(req_t kind, int yr, int mo, int dy, int hr, int mn, int sec,
			bit typed, cal_result_t res);
		dir_row_t row;
		row.kind           = kind;
		row.req.set_year   = 8'(yr);
		row.req.set_month  = 4'(mo);
		row.req.set_day    = 5'(dy);
		row.req.set_hour   = 8'(hr);
		row.req.set_minute = 8'(mn);
		row.req.set_second = 8'(sec);
		row.typed          = typed;
		row.res            = res;
		dir_tab.push_back(row);
	endtask

	task automatic send_item(req_t kind, rtc_req_t rq, bit typed, cal_result_t typed_res);
		int          gap;
		cal_result_t pred;
		gap = burst ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {{(IN_DATA_W - $bits(rtc_req_t)){1'b0}}, rq};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pred = advance_calendar(kind, rq);
		calendar_due.push_back(typed ? typed_res : pred);
		if (kind == REQ_SET)
			set_count++;
		else
			tick_count++;
		@(negedge clk);
	endtask

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			err_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	task automatic make_set(output rtc_req_t rq);
		case ($urandom_range(0, 2))
			0: begin
				rq.set_year   = 8'($urandom);
				rq.set_month  = 4'($urandom);
				rq.set_day    = 5'($urandom);
				rq.set_hour   = 8'($urandom);
				rq.set_minute = 8'($urandom);
				rq.set_second = 8'($urandom);
			end
			1: begin
				rq.set_year   = 8'($urandom_range(0, 255));
				rq.set_month  = 4'($urandom_range(0, 15));
				rq.set_day    = 5'($urandom_range(26, 31));
				rq.set_hour   = 8'd23;
				rq.set_minute = 8'd59;
				rq.set_second = 8'($urandom_range(52, 59));
			end
			default: begin
				rq.set_year   = 8'($urandom_range(0, 255));
				rq.set_month  = 4'($urandom_range(1, 12));
				rq.set_day    = 5'($urandom_range(1, 28));
				rq.set_hour   = 8'($urandom_range(0, 23));
				rq.set_minute = 8'($urandom_range(55, 59));
				rq.set_second = 8'($urandom_range(45, 59));
			end
		endcase
	endtask

	initial begin
		int          w;
		cal_result_t want;
		cal_result_t got;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			w = burst ? 0 : $urandom_range(0, MAX_WAIT);
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			got = m_tdata;
			if (calendar_due.size() == 0) begin
				err_count++;
				$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
			end else begin
				want = calendar_due.pop_front();
				check_field("second", int'(want.tm.second), int'(got.tm.second));
				check_field("minute", int'(want.tm.minute), int'(got.tm.minute));
				check_field("hour", int'(want.tm.hour), int'(got.tm.hour));
				check_field("day", int'(want.tm.day), int'(got.tm.day));
				check_field("month", int'(want.tm.month), int'(got.tm.month));
				check_field("year", int'(want.tm.year), int'(got.tm.year));
				check_field("minute_event", int'(want.ev.minute), int'(got.ev.minute));
				check_field("hour_event", int'(want.ev.hour), int'(got.ev.hour));
				check_field("day_event", int'(want.ev.day), int'(got.ev.day));
				check_field("month_event", int'(want.ev.month), int'(got.ev.month));
				check_field("year_event", int'(want.ev.year), int'(got.ev.year));
				carry_min  += int'(want.ev.minute);
				carry_hour += int'(want.ev.hour);
				carry_day  += int'(want.ev.day);
				carry_mon  += int'(want.ev.month);
				carry_year += int'(want.ev.year);
			end
			@(negedge clk);
		end
	end

	initial begin
		cal_result_t none;
		rtc_req_t    rq;
		none     = '0;
		s_tvalid = 1'b0;
		s_tuser  = REQ_TICK;
		s_tdata  = '0;
		arst_n   = 1'b0;
		cal_sec  = 6'd0;
		cal_min  = 6'd0;
		cal_hour = 5'd0;
		cal_day  = 5'd1;
		cal_mon  = 4'd1;
		cal_year = 8'd0;

		add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 1'b1, mk_res(1, 0, 0, 1, 1, 0, 5'b00000));
		add_row(REQ_SET, 255, 12, 31, 255, 255, 255, 1'b1,
			mk_res(0, 0, 0, 31, 12, 0, 5'b00000));
		add_row(REQ_SET, 254, 12, 31, 23, 59, 59, 1'b1,
			mk_res(59, 59, 23, 31, 12, 254, 5'b00000));
		add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 1'b1, mk_res(0, 0, 0, 1, 1, 255, 5'b11111));
		add_row(REQ_SET, 3, 9, 15, 24, 60, 60, 1'b1, mk_res(0, 0, 0, 15, 9, 3, 5'b00000));
		add_row(REQ_SET, 10, 7, 20, 10, 20, 59, 1'b0, none);
		add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 1'b0, none);
		add_row(REQ_SET, 10, 7, 20, 10, 59, 59, 1'b0, none);
		add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 1'b0, none);
		add_row(REQ_SET, 4, 2, 28, 23, 59, 59, 1'b0, none);
		add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 1'b0, none);
		add_row(REQ_SET, 4, 2, 29, 23, 59, 59, 1'b0, none);
		add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 1'b0, none);
		add_row(REQ_SET, 5, 2, 28, 23, 59, 59, 1'b0, none);
		add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 1'b0, none);
		add_row(REQ_SET, 1, 4, 30, 23, 59, 59, 1'b0, none);
		add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 1'b0, none);
		add_row(REQ_SET, 1, 4, 31, 23, 59, 59, 1'b0, none);
		add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 1'b0, none);
		add_row(REQ_SET, 7, 0, 30, 23, 59, 59, 1'b0, none);
		add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 1'b0, none);
		add_row(REQ_SET, 10, 15, 31, 23, 59, 59, 1'b0, none);
		add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 1'b0, none);
		add_row(REQ_SET, 8, 6, 0, 23, 59, 59, 1'b0, none);
		add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 1'b0, none);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_tab[i])
			send_item(dir_tab[i].kind, dir_tab[i].req, dir_tab[i].typed, dir_tab[i].res);

		// hold until the directed results have drained
		s_tvalid <= 1'b0;
		while (calendar_due.size() != 0)
			@(negedge clk);
		@(negedge clk);

		for (int n = 0; n < ITEM_COUNT; n++) begin
			if (n % 100 == 0)
				burst = ($urandom_range(0, 3) == 0);
			if (n == ITEM_COUNT / 2) begin
				s_tvalid <= 1'b0;
				while (calendar_due.size() != 0)
					@(negedge clk);
				@(negedge clk);
			end
			rq = '0;
			if ($urandom_range(0, 7) == 0) begin
				make_set(rq);
				send_item(REQ_SET, rq, 1'b0, none);
			end else begin
				rq.set_year   = 8'($urandom);
				rq.set_hour   = 8'($urandom);
				rq.set_second = 8'($urandom);
				send_item(REQ_TICK, rq, 1'b0, none);
			end
		end
		s_tvalid <= 1'b0;

		while (calendar_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d tick items and %0d set items", tick_count, set_count);
		$display("carries: minute %0d, hour %0d, day %0d, month %0d, year %0d",
			carry_min, carry_hour, carry_day, carry_mon, carry_year);
		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
